[hdl/vptb_pkg.sv]
`default_nettype none

package vptb_pkg;

    // Item field widths
    localparam int OPERATION_W = 2;
    localparam int CLIENT_W    = 3;
    localparam int FREQUENCY_W = 32;
    localparam int MASK_W      = 8;

    // Width of the in-range compare on client_index (covers up to 64 clients)
    localparam int CLIENT_CMP_W = 6;

    // Defaults for the top-level parameters
    localparam int DEFAULT_CLIENT_COUNT   = 8;
    localparam int DEFAULT_BASE_FREQUENCY = 1024;

    // Operation codes
    localparam logic [OPERATION_W-1:0] OP_TICK     = 2'd0;
    localparam logic [OPERATION_W-1:0] OP_SET_FREQ = 2'd1;
    localparam logic [OPERATION_W-1:0] OP_ARM      = 2'd2;

    // Decoded command handed to the counter bank
    typedef struct packed {
        logic                tick;
        logic                set_freq;
        logic                arm;
        logic [CLIENT_W-1:0] client;
    } cmd_t;

endpackage

`default_nettype wire

[hdl/virtual_periodic_timer_bank.sv]
`default_nettype none

// Virtual periodic timer bank: CLIENT_COUNT down counters run off a base tick.
// Command channel: start with operation / client_index / frequency is taken
// on a rising edge where start is high and busy is low. busy is held low,
// so one item can be issued every cycle.
// Operations: tick decrements all nonzero counters and flags every counter
// at zero; set frequency checks for a nonzero power of two and stores
// BASE_FREQUENCY >> log2(frequency) (0 above base); arm clears the flag and
// reloads the counter. Out-of-range clients change no state.
// Result channel: done pulses for one cycle with error and expired_mask (flags
// after the operation). The item is held in the input register while the
// counter bank works out its update, then the bank and the result register
// load together and done shows the result. Throughput is one item per cycle,
// set by the single registered pass through the counter bank.
// The receiver cannot stall; every result is shown exactly once.
// Reset (rst_n low, asynchronous) clears all counters, reload values, flags
// and any item in flight.
module virtual_periodic_timer_bank #(
    parameter int CLIENT_COUNT   = vptb_pkg::DEFAULT_CLIENT_COUNT,
    parameter int BASE_FREQUENCY = vptb_pkg::DEFAULT_BASE_FREQUENCY
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic [vptb_pkg::OPERATION_W-1:0] operation,
    input  wire logic [vptb_pkg::CLIENT_W-1:0]    client_index,
    input  wire logic [vptb_pkg::FREQUENCY_W-1:0] frequency,
    output logic                                  done,
    output logic                                  error,
    output logic      [vptb_pkg::MASK_W-1:0]      expired_mask
);

    // counter width holds the largest reload value, BASE_FREQUENCY itself
    localparam int CW = $clog2(BASE_FREQUENCY + 1);

    // input register
    logic                             in_valid_reg;
    logic [vptb_pkg::OPERATION_W-1:0] op_reg;
    logic [vptb_pkg::CLIENT_W-1:0]    client_reg;
    logic [vptb_pkg::FREQUENCY_W-1:0] freq_reg;

    // result register
    logic                        done_reg;
    logic                        error_reg;
    logic                        error_next;
    logic [vptb_pkg::MASK_W-1:0] mask_reg;
    logic [vptb_pkg::MASK_W-1:0] mask_next;

    vptb_pkg::cmd_t cmd;
    logic           bad_freq;
    logic [CW-1:0]  new_reload;

    // never holds off the issuer
    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            op_reg     <= operation;
            client_reg <= client_index;
            freq_reg   <= frequency;
        end
    end

    // operation decode; code 3 does nothing
    always_comb
    begin
        cmd        = '0;
        cmd.client = client_reg;
        unique case (op_reg)
            vptb_pkg::OP_TICK:     cmd.tick     = 1'b1;
            vptb_pkg::OP_SET_FREQ: cmd.set_freq = 1'b1;
            vptb_pkg::OP_ARM:      cmd.arm      = 1'b1;
            default:               ;
        endcase
    end

    vptb_reload_calc #(
        .BASE_FREQUENCY(BASE_FREQUENCY),
        .CW            (CW)
    ) u_reload_calc (
        .frequency(freq_reg),
        .bad_freq (bad_freq),
        .reload   (new_reload)
    );

    vptb_counter_bank #(
        .CLIENT_COUNT  (CLIENT_COUNT),
        .BASE_FREQUENCY(BASE_FREQUENCY),
        .CW            (CW)
    ) u_counter_bank (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (in_valid_reg),
        .cmd       (cmd),
        .bad_freq  (bad_freq),
        .new_reload(new_reload),
        .mask_next (mask_next)
    );

    // error only reported for set frequency
    assign error_next = cmd.set_freq && bad_freq;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            error_reg <= error_next;
            mask_reg  <= mask_next;
        end
    end

    assign done         = done_reg;
    assign error        = error_reg;
    assign expired_mask = mask_reg;

endmodule

`default_nettype wire

[hdl/vptb_reload_calc.sv]
`default_nettype none

// Validates a requested frequency and derives BASE_FREQUENCY / frequency.
// Frequency is a power of two, so the divide is a right shift by its log2.
module vptb_reload_calc #(
    parameter int BASE_FREQUENCY = vptb_pkg::DEFAULT_BASE_FREQUENCY,
    parameter int CW             = $clog2(BASE_FREQUENCY + 1)
) (
    input  wire logic [vptb_pkg::FREQUENCY_W-1:0] frequency,
    output logic                                  bad_freq,
    output logic [CW-1:0]                         reload
);

    localparam logic [vptb_pkg::FREQUENCY_W-1:0] BASE_VEC =
        vptb_pkg::FREQUENCY_W'(BASE_FREQUENCY);
    localparam int LOG_W = $clog2(vptb_pkg::FREQUENCY_W);

    logic [LOG_W-1:0]                 freq_log2;
    logic [vptb_pkg::FREQUENCY_W-1:0] shifted;

    // one-hot to binary: OR of bit positions
    always_comb
    begin
        freq_log2 = '0;
        for (int b = 0; b < vptb_pkg::FREQUENCY_W; b++)
        begin
            if (frequency[b])
            begin
                freq_log2 = freq_log2 | LOG_W'(b);
            end
        end
    end

    assign bad_freq = (frequency == '0) ||
                      ((frequency & (frequency - 1'b1)) != '0);

    assign shifted = BASE_VEC >> freq_log2;

    // above base frequency the quotient is zero
    assign reload = (frequency > BASE_VEC) ? '0 : shifted[CW-1:0];

endmodule

`default_nettype wire

[hdl/vptb_counter_bank.sv]
`default_nettype none

// Per-client reload values, down counters and expired flags.
// Applies one decoded command per cycle; mask shows the flags after it.
module vptb_counter_bank #(
    parameter int CLIENT_COUNT   = vptb_pkg::DEFAULT_CLIENT_COUNT,
    parameter int BASE_FREQUENCY = vptb_pkg::DEFAULT_BASE_FREQUENCY,
    parameter int CW             = $clog2(BASE_FREQUENCY + 1)
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cmd_valid,
    input  wire vptb_pkg::cmd_t               cmd,
    input  wire logic                         bad_freq,
    input  wire logic [CW-1:0]                new_reload,
    output logic      [vptb_pkg::MASK_W-1:0]  mask_next
);

    localparam int CMPW = vptb_pkg::CLIENT_CMP_W;

    logic [CW-1:0] reload_reg   [CLIENT_COUNT];
    logic [CW-1:0] reload_next  [CLIENT_COUNT];
    logic [CW-1:0] counter_reg  [CLIENT_COUNT];
    logic [CW-1:0] counter_next [CLIENT_COUNT];
    logic          flag_reg     [CLIENT_COUNT];
    logic          flag_next    [CLIENT_COUNT];
    logic [CMPW-1:0] client_ext;

    assign client_ext = CMPW'(cmd.client);

    always_comb
    begin
        for (int i = 0; i < CLIENT_COUNT; i++)
        begin
            reload_next[i]  = reload_reg[i];
            counter_next[i] = counter_reg[i];
            flag_next[i]    = flag_reg[i];
            if (cmd_valid)
            begin
                if (cmd.tick)
                begin
                    if (counter_reg[i] != '0)
                    begin
                        counter_next[i] = counter_reg[i] - 1'b1;
                    end
                    // already-zero counters expire too
                    if (counter_next[i] == '0)
                    begin
                        flag_next[i] = 1'b1;
                    end
                end
                else if (cmd.set_freq && !bad_freq && client_ext == CMPW'(i))
                begin
                    reload_next[i] = new_reload;
                end
                else if (cmd.arm && client_ext == CMPW'(i))
                begin
                    flag_next[i]    = 1'b0;
                    counter_next[i] = reload_reg[i];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CLIENT_COUNT; i++)
            begin
                reload_reg[i]  <= '0;
                counter_reg[i] <= '0;
                flag_reg[i]    <= 1'b0;
            end
        end
        else
        begin
            for (int i = 0; i < CLIENT_COUNT; i++)
            begin
                reload_reg[i]  <= reload_next[i];
                counter_reg[i] <= counter_next[i];
                flag_reg[i]    <= flag_next[i];
            end
        end
    end

    // clients past the mask width have no bit
    always_comb
    begin
        mask_next = '0;
        for (int i = 0; i < vptb_pkg::MASK_W; i++)
        begin
            if (i < CLIENT_COUNT)
            begin
                mask_next[i] = flag_next[i];
            end
        end
    end

endmodule

`default_nettype wire
